// File: src/chtm_pkg.sv
// Shared constants, types and the CRC-32C bucket hash for the 32-byte key map.
// Depends on nothing; every other file of the map imports this package.
package chtm_pkg;

   localparam int BUCKETS  = 256;
   localparam int WAYS     = 4;
   localparam int SLOTS    = BUCKETS * WAYS;

   localparam int KEY_W    = 256;
   localparam int WORD_W   = 64;
   localparam int VALUE_W  = 64;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;
   localparam int CRC_W    = 32;

   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [BUCKET_W-1:0] BUCKET_MASK = BUCKET_W'(BUCKETS - 1);
   localparam logic [BUCKET_W-1:0] BUCKET_LAST = BUCKET_W'(BUCKETS - 1);

   localparam logic [CRC_W-1:0] CRC32C_POLY = 32'h82F6_3B78;

   // Command codes. The unused code behaves as a find.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEL_MISS  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VALUE_W-1:0] value_type;

   // One bucket row of the table memory.
   typedef struct packed {
      logic [WAYS-1:0]              valid;
      logic [WAYS-1:0][KEY_W-1:0]   key;
      logic [WAYS-1:0][VALUE_W-1:0] value;
   } row_type;

   typedef logic [CRC_W-1:0][KEY_W-1:0] crc_mat_type;

   // With a zero seed and no final xor the CRC is linear in the key bits, so each
   // CRC bit is the parity of the key under a fixed mask. Key bit i is the i-th bit
   // shifted in (word 0 first, each byte low bit first), which matches the byte-wise
   // reflected algorithm.
   function automatic crc_mat_type crc_matrix();
      crc_mat_type m;
      logic [CRC_W-1:0] crc;
      m = '0;
      for (int j = 0; j < KEY_W; j++) begin
         crc = '0;
         for (int i = j; i < KEY_W; i++) begin
            if (i == j) begin
               crc[0] = ~crc[0];
            end
            crc = crc[0] ? ((crc >> 1) ^ CRC32C_POLY) : (crc >> 1);
         end
         for (int o = 0; o < CRC_W; o++) begin
            m[o][j] = crc[o];
         end
      end
      return m;
   endfunction

   localparam crc_mat_type CRC_MATRIX = crc_matrix();

   // Bucket index: low CRC bits masked with the bucket count minus one.
   function automatic logic [BUCKET_W-1:0] bucket_of(key_type key);
      logic [BUCKET_W-1:0] h;
      for (int o = 0; o < BUCKET_W; o++) begin
         h[o] = ^(key & CRC_MATRIX[o]);
      end
      return h & BUCKET_MASK;
   endfunction

endpackage

// File: src/chtm_req_if.sv
// Request channel of the key map: valid/ready handshake carrying one operation.
// Depends on chtm_pkg for the field widths.
interface chtm_req_if import chtm_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [WORD_W-1:0]    key_word0;
   logic [WORD_W-1:0]    key_word1;
   logic [WORD_W-1:0]    key_word2;
   logic [WORD_W-1:0]    key_word3;
   logic [VALUE_W-1:0]   value_in;

   modport source (
      output valid, cmd, key_word0, key_word1, key_word2, key_word3, value_in,
      input  ready
   );

   modport sink (
      input  valid, cmd, key_word0, key_word1, key_word2, key_word3, value_in,
      output ready
   );

endinterface

// File: src/chtm_rsp_if.sv
// Response channel of the key map: valid/ready handshake carrying one result.
// Depends on chtm_pkg for the field widths.
interface chtm_rsp_if import chtm_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [VALUE_W-1:0]   value_out;
   logic [COUNT_W-1:0]   entry_count;

   modport source (
      output valid, status, value_out, entry_count,
      input  ready
   );

   modport sink (
      input  valid, status, value_out, entry_count,
      output ready
   );

endinterface

// File: src/crc32c_hash_table_map_core.sv
// Top level of the CRC-32C hashed key/value map with fixed-size buckets.
// Depends on chtm_pkg, chtm_req_if and chtm_rsp_if.
//
//   Channel    Dir   Handshake         Carries
//   req_chan   in    valid / ready     cmd, key_word0..3, value_in
//   rsp_chan   out   valid / ready     status, value_out, entry_count
//
// Each item is read and then written back: the cycle it is accepted reads its bucket
// row from the table memory, and the S_LOOKUP state compares all ways and writes the
// row back. No new item is accepted until that write-back is done.
// After reset the block sweeps the memory to clear the valid bits, one bucket per
// cycle, before it accepts the first item.
// A result waits in the output register; a new item is still accepted, and its
// write-back simply holds until the output register is free.
module crc32c_hash_table_map_core import chtm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   chtm_req_if.sink     req_chan,
   chtm_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP
   } state_type;

   // Control and captured item.
   state_type            state_ff,       state_in;
   logic [BUCKET_W-1:0]  clear_idx_ff,   clear_idx_in;
   logic [COUNT_W-1:0]   count_ff,       count_in;
   logic                 rsp_valid_ff,   rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff,  rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff,   rsp_value_in;
   logic [CMD_W-1:0]     cmd_ff,         cmd_in;
   key_type              key_ff,         key_in;
   value_type            value_ff,       value_in;
   logic [BUCKET_W-1:0]  bucket_ff,      bucket_in;

   // Table memory: one row per bucket holding valid bits, keys and values.
   row_type              bucket_mem [BUCKETS];
   row_type              rd_row_ff;
   logic                 mem_we;
   logic [BUCKET_W-1:0]  mem_waddr;
   row_type              mem_wdata;

   logic                 req_accept;
   logic                 lookup_go;
   key_type              req_key;
   logic [BUCKET_W-1:0]  req_bucket;

   // Lookup datapath.
   logic [WAYS-1:0]      hit_vec;
   logic [WAYS-1:0]      free_vec;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     free_way;
   logic                 any_hit;
   logic                 any_free;
   row_type              wr_row;
   logic [STATUS_W-1:0]  lk_status;
   logic [VALUE_W-1:0]   lk_value;
   logic [COUNT_W-1:0]   lk_count;

   // The request is taken whenever no item is in flight and the sweep is done.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == S_IDLE);

   // The write-back stalls only while the previous result is still unread.
   assign lookup_go = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_key    = {req_chan.key_word3, req_chan.key_word2,
                        req_chan.key_word1, req_chan.key_word0};
   assign req_bucket = bucket_of(req_key);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.value_out   = rsp_value_ff;
   assign rsp_chan.entry_count = count_ff;

   // Compare every way of the fetched bucket against the key and pick the lowest
   // matching way and the lowest free way.
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w]  = rd_row_ff.valid[w] && (rd_row_ff.key[w] == key_ff);
         free_vec[w] = !rd_row_ff.valid[w];
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (free_vec[w]) begin
            free_way = WAY_W'(w);
         end
      end
      any_hit  = |hit_vec;
      any_free = |free_vec;
   end

   // Apply the operation to the fetched row and form the result.
   always_comb begin
      wr_row    = rd_row_ff;
      lk_status = ST_NOT_FOUND;
      lk_value  = '0;
      lk_count  = count_ff;
      case (cmd_ff)
         CMD_INSERT: begin
            if (any_hit) begin
               wr_row.value[hit_way] = value_ff;
               lk_status             = ST_UPDATED;
            end else if (any_free) begin
               wr_row.valid[free_way] = 1'b1;
               wr_row.key[free_way]   = key_ff;
               wr_row.value[free_way] = value_ff;
               lk_count               = count_ff + 1'b1;
               lk_status              = ST_INSERTED;
            end else begin
               lk_status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (any_hit) begin
               wr_row.valid[hit_way] = 1'b0;
               lk_count              = count_ff - 1'b1;
               lk_status             = ST_DELETED;
            end else begin
               lk_status = ST_DEL_MISS;
            end
         end
         default: begin
            // Find, and the unused code that acts as a find.
            if (any_hit) begin
               lk_value  = rd_row_ff.value[hit_way];
               lk_status = ST_FOUND;
            end else begin
               lk_value  = '1;
               lk_status = ST_NOT_FOUND;
            end
         end
      endcase
   end

   // The sweep after reset and the write-back of a lookup share the write port.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = lookup_go;
         mem_waddr = bucket_ff;
         mem_wdata = wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_row_ff <= bucket_mem[req_bucket];
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      clear_idx_in  = clear_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      bucket_in     = bucket_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == BUCKET_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_chan.cmd;
               key_in    = req_key;
               value_in  = req_chan.value_in;
               bucket_in = req_bucket;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (lookup_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lk_status;
               rsp_value_in  = lk_value;
               count_in      = lk_count;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      bucket_ff     <= bucket_in;
   end

   // The entry count can never exceed the number of slots in the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(count_ff) <= SLOTS))
      else $error("entry count exceeds table capacity");

   // The count changes only when a lookup writes back.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> $past(lookup_go))
      else $error("entry count changed outside a write-back");

   // A new result appears only right after a lookup cycle.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_LOOKUP))
      else $error("result raised without a lookup");

   // Inserts and deletes report a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_FOUND) && (rsp_status_ff != ST_NOT_FOUND))
         |-> (rsp_value_ff == '0))
      else $error("nonzero value on insert or delete result");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-32C bucketed key/value map core.
// Depends on chtm_pkg, chtm_req_if, chtm_rsp_if and crc32c_hash_table_map_core.
module testbench import chtm_pkg::*; ();

   // The spare command code is not named in the package. The block treats it as a find.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // This sets how long the receiver holds off during the backpressure test.
   localparam int RSP_HOLD_CYCLES = 300;

   // One expected reply, in the form the response channel carries it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
   } map_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chtm_req_if req_if ();
   chtm_rsp_if rsp_if ();

   crc32c_hash_table_map_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // The clock period is 12 ns, with equal high and low phases.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the table. Only slots whose valid bit is set are ever compared
   // or read, so the key and value arrays need no clearing.
   logic                 shadow_valid [SLOTS];
   key_type              shadow_key   [SLOTS];
   value_type            shadow_value [SLOTS];
   logic [COUNT_W-1:0]   shadow_count;

   // These are the replies predicted for accepted requests, oldest first.
   map_reply_type pending_replies [$];

   int unsigned error_count   = 0;
   int unsigned requests_sent = 0;
   int unsigned replies_seen  = 0;
   int unsigned status_seen [8];

   // Pacing controls. A burst flag switches off the random gaps for a while, so
   // that back-to-back stretches occur on both sides.
   bit send_burst      = 1'b0;
   bit sender_flat_out = 1'b0;
   bit rsp_burst       = 1'b0;
   logic rsp_hold      = 1'b0;
   event stall_begin;

   // The CRC-32C is computed byte by byte, low bit first, over the 32 key bytes.
   // Word 0 is fed first. The seed is zero and there is no final xor.
   function automatic logic [CRC_W-1:0] crc32c_of_key(key_type key);
      logic [CRC_W-1:0] crc;
      crc = '0;
      for (int n = 0; n < KEY_W / 8; n++) begin
         crc ^= {24'd0, key[8*n +: 8]};
         for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC32C_POLY) : (crc >> 1);
         end
      end
      return crc;
   endfunction

   function automatic int unsigned bucket_index(key_type key);
      return int'(crc32c_of_key(key) & 32'(BUCKETS - 1));
   endfunction

   // This applies one request to the shadow table and returns the reply the block
   // must give. The hit is the first valid way with an equal key, and a new entry
   // goes into the lowest free way.
   function automatic map_reply_type apply_to_shadow_map(logic [CMD_W-1:0] cmd,
                                                         key_type key, value_type val);
      map_reply_type reply;
      int base;
      int hit;
      int free_way;
      base     = bucket_index(key) * WAYS;
      hit      = -1;
      free_way = -1;
      for (int way = 0; way < WAYS; way++) begin
         if (shadow_valid[base + way]) begin
            if (hit < 0 && shadow_key[base + way] == key) begin
               hit = way;
            end
         end else if (free_way < 0) begin
            free_way = way;
         end
      end
      reply.value = '0;
      case (cmd)
         CMD_INSERT: begin
            if (hit >= 0) begin
               // A matching key is updated even when every way is taken.
               shadow_value[base + hit] = val;
               reply.status = ST_UPDATED;
            end else if (free_way >= 0) begin
               shadow_valid[base + free_way] = 1'b1;
               shadow_key[base + free_way]   = key;
               shadow_value[base + free_way] = val;
               shadow_count = shadow_count + 1'b1;
               reply.status = ST_INSERTED;
            end else begin
               reply.status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (hit >= 0) begin
               shadow_valid[base + hit] = 1'b0;
               shadow_count = shadow_count - 1'b1;
               reply.status = ST_DELETED;
            end else begin
               reply.status = ST_DEL_MISS;
            end
         end
         default: begin
            // Both the find code and the spare code end up here.
            if (hit >= 0) begin
               reply.value  = shadow_value[base + hit];
               reply.status = ST_FOUND;
            end else begin
               reply.value  = '1;
               reply.status = ST_NOT_FOUND;
            end
         end
      endcase
      reply.count = shadow_count;
      return reply;
   endfunction

   function automatic key_type random_key();
      key_type k;
      for (int i = 0; i < KEY_W / 32; i++) begin
         k[32*i +: 32] = $urandom;
      end
      return k;
   endfunction

   // This searches for a random key that lands in the given bucket. It takes about
   // BUCKETS tries on average and costs no simulated time.
   function automatic key_type key_in_bucket(int unsigned bucket);
      key_type k;
      do begin
         k = random_key();
      end while (bucket_index(k) != bucket);
      return k;
   endfunction

   function automatic value_type random_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Inserts dominate a little, so that buckets fill up. The spare code appears
   // now and then.
   function automatic logic [CMD_W-1:0] random_cmd();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return CMD_INSERT;
      end else if (r < 70) begin
         return CMD_DELETE;
      end else if (r < 95) begin
         return CMD_FIND;
      end
      return CMD_SPARE;
   endfunction

   function automatic int unsigned draw_rsp_wait();
      if ($urandom_range(0, 15) == 0) begin
         rsp_burst = !rsp_burst;
      end
      return rsp_burst ? 0 : $urandom_range(0, 14);
   endfunction

   // This offers one request and returns at the edge that accepts it. The reply is
   // predicted at that edge. Valid is lowered only when a gap follows, so it never
   // gets two assignments in one time step.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input key_type key,
                               input value_type val);
      int unsigned gap;
      if (!sender_flat_out && $urandom_range(0, 15) == 0) begin
         send_burst = !send_burst;
      end
      gap = (sender_flat_out || send_burst) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.cmd       <= cmd;
      req_if.key_word0 <= key[0*WORD_W +: WORD_W];
      req_if.key_word1 <= key[1*WORD_W +: WORD_W];
      req_if.key_word2 <= key[2*WORD_W +: WORD_W];
      req_if.key_word3 <= key[3*WORD_W +: WORD_W];
      req_if.value_in  <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_replies.push_back(apply_to_shadow_map(cmd, key, val));
      requests_sent++;
   endtask

   // This compares the reply accepted at this edge with the oldest prediction.
   task automatic check_reply();
      map_reply_type want;
      replies_seen++;
      status_seen[rsp_if.status]++;
      if (pending_replies.size() == 0) begin
         $error("reply %0d arrived with no request outstanding (status %0d)",
                replies_seen, rsp_if.status);
         error_count++;
      end else begin
         want = pending_replies.pop_front();
         if (rsp_if.status !== want.status) begin
            $error("reply %0d status: expected %0d, actual %0d",
                   replies_seen, want.status, rsp_if.status);
            error_count++;
         end
         if (rsp_if.value_out !== want.value) begin
            $error("reply %0d value_out: expected %h, actual %h",
                   replies_seen, want.value, rsp_if.value_out);
            error_count++;
         end
         if (rsp_if.entry_count !== want.count) begin
            $error("reply %0d entry_count: expected %0d, actual %0d",
                   replies_seen, want.count, rsp_if.entry_count);
            error_count++;
         end
      end
   endtask

   // The response side draws a stall before each item. The hold flag from the
   // backpressure process overrides it. Ready is driven once per edge.
   initial begin : reply_receiver
      int unsigned wait_left;
      rsp_if.ready = 1'b0;
      wait_left = draw_rsp_wait();
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_if.valid && rsp_if.ready) begin
               check_reply();
               wait_left = draw_rsp_wait();
            end else if (wait_left != 0) begin
               wait_left--;
            end
            rsp_if.ready <= !rsp_hold && (wait_left == 0);
         end
      end
   end

   // The long receiver hold-off is counted here. It is updated with nonblocking
   // assignments, so the receiver sees it at a fixed point in each edge.
   initial begin : reply_hold_off
      forever begin
         @(stall_begin);
         rsp_hold <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Corner cases on a nearly empty table. It covers the all-zero and all-one keys,
   // update in place, the spare command, and a bucket driven full, together with
   // update and delete inside the full bucket and reuse of the freed way.
   task automatic test_directed_corners();
      key_type zero_key;
      key_type ones_key;
      key_type same [6];
      int unsigned b;
      zero_key = '0;
      ones_key = '1;
      send_request(CMD_FIND,   zero_key, random_value());
      send_request(CMD_DELETE, zero_key, random_value());
      send_request(CMD_INSERT, zero_key, '0);
      send_request(CMD_INSERT, zero_key, '1);
      send_request(CMD_FIND,   zero_key, '0);
      send_request(CMD_SPARE,  zero_key, random_value());
      send_request(CMD_INSERT, ones_key, '0);
      send_request(CMD_FIND,   ones_key, '1);
      send_request(CMD_DELETE, zero_key, '1);
      send_request(CMD_FIND,   zero_key, '0);

      // Choose a bucket away from the two extreme keys, so that it fills at exactly
      // WAYS entries.
      do begin
         b = $urandom_range(0, BUCKETS - 1);
      end while (b == bucket_index(zero_key) || b == bucket_index(ones_key));
      foreach (same[i]) begin
         same[i] = key_in_bucket(b);
      end
      for (int i = 0; i < WAYS; i++) begin
         send_request(CMD_INSERT, same[i], random_value());
      end
      send_request(CMD_INSERT, same[4], random_value());
      send_request(CMD_INSERT, same[2], random_value());
      send_request(CMD_FIND,   same[4], random_value());
      send_request(CMD_DELETE, same[4], random_value());
      send_request(CMD_DELETE, same[1], random_value());
      send_request(CMD_INSERT, same[4], random_value());
      send_request(CMD_FIND,   same[4], random_value());
      send_request(CMD_INSERT, same[5], random_value());
      send_request(CMD_FIND,   same[2], random_value());
      send_request(CMD_DELETE, ones_key, random_value());
   endtask

   // Most traffic targets a pool of keys crowded into a few buckets, so that hits,
   // updates, full buckets and delete misses all recur. The rest uses fresh keys.
   task automatic test_random_traffic(input int unsigned count);
      key_type pool [$];
      key_type key;
      int unsigned hot;
      hot = 0;
      for (int h = 0; h < 6; h++) begin
         hot = $urandom_range(0, BUCKETS - 1);
         for (int i = 0; i < WAYS + 2; i++) begin
            pool.push_back(key_in_bucket(hot));
         end
      end
      for (int i = 0; i < 12; i++) begin
         pool.push_back(random_key());
      end
      pool.push_back('0);
      pool.push_back('1);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            key = pool[$urandom_range(0, pool.size() - 1)];
         end else begin
            key = random_key();
         end
         send_request(random_cmd(), key, random_value());
      end
   endtask

   // The receiver stops for a long stretch while the sender offers requests without
   // gaps. The block must fill, stall its input and then drain in order.
   task automatic test_output_backpressure(input int unsigned count);
      -> stall_begin;
      sender_flat_out = 1'b1;
      test_random_traffic(count);
      sender_flat_out = 1'b0;
   endtask

   // Many fresh keys are inserted to raise the entry count, then looked up and
   // mostly deleted again.
   task automatic test_bulk_fill(input int unsigned count);
      key_type fresh [$];
      for (int i = 0; i < count; i++) begin
         fresh.push_back(random_key());
         send_request(CMD_INSERT, fresh[i], random_value());
      end
      foreach (fresh[i]) begin
         send_request(CMD_FIND, fresh[i], random_value());
      end
      for (int i = 0; i < count - 20; i++) begin
         send_request(CMD_DELETE, fresh[i], random_value());
      end
   endtask

   initial begin : stimulus
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_INSERT;
      req_if.key_word0 = '0;
      req_if.key_word1 = '0;
      req_if.key_word2 = '0;
      req_if.key_word3 = '0;
      req_if.value_in  = '0;
      foreach (shadow_valid[i]) begin
         shadow_valid[i] = 1'b0;
      end
      shadow_count = '0;
      foreach (status_seen[i]) begin
         status_seen[i] = 0;
      end

      // Reset is held high first, then released. The block then sweeps its memory and keeps
      // ready low until the sweep is done, and the handshake absorbs that wait.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_traffic(720);
      test_output_backpressure(40);
      test_bulk_fill(170);

      // Drop valid, wait for every outstanding reply, then wait on so that a stray extra
      // reply would still be caught.
      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending_replies.size() != 0) begin
         $error("%0d replies never arrived", pending_replies.size());
         error_count++;
      end
      $display("Covered %0d requests, %0d replies; inserted %0d, updated %0d, full %0d",
               requests_sent, replies_seen, status_seen[ST_INSERTED],
               status_seen[ST_UPDATED], status_seen[ST_FULL]);
      $display("Deleted %0d, delete misses %0d, found %0d, not found %0d, final count %0d",
               status_seen[ST_DELETED], status_seen[ST_DEL_MISS], status_seen[ST_FOUND],
               status_seen[ST_NOT_FOUND], shadow_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // The slowest correct run stays under about 0.5 ms. This allows several times
   // that.
   initial begin : run_limit
      #5_000_000;
      $error("timeout with %0d replies outstanding", pending_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: crc32c_hash_table_map_core.f
src/chtm_pkg.sv
src/chtm_req_if.sv
src/chtm_rsp_if.sv
src/crc32c_hash_table_map_core.sv
tb/sv/testbench.sv
